@@ hw/rtl/acoustic_upwind_flux_defines.svh @@
// Assertion macros shared by the acoustic upwind flux RTL.
// Needs a clock clk_i and an active-low reset rst_ni in the including scope.
`ifndef ACOUSTIC_UPWIND_FLUX_DEFINES_SVH
`define ACOUSTIC_UPWIND_FLUX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AUF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AUF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/auf_pkg.sv @@
// Types, micro-op table and saturating helpers for the acoustic upwind flux.
// Used by auf_alu and acoustic_upwind_flux; depends on nothing.
package auf_pkg;

  localparam int DATA_W  = 32;
  localparam int IW      = 64;
  localparam int GAMMA_W = 19;
  localparam int STEP_W  = 5;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 19'd91750;
  localparam logic [STEP_W-1:0]  LAST_STEP   = 5'd31;
  localparam logic [IW-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [IW-1:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic                     side;
    logic signed [DATA_W-1:0] pressure;
    logic signed [DATA_W-1:0] x_velocity;
    logic signed [DATA_W-1:0] y_velocity;
    logic signed [DATA_W-1:0] z_velocity;
    logic signed [DATA_W-1:0] base_pressure;
    logic signed [DATA_W-1:0] base_density;
    logic signed [DATA_W-1:0] base_x_velocity;
    logic signed [DATA_W-1:0] base_y_velocity;
    logic signed [DATA_W-1:0] base_z_velocity;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pressure_flux;
    logic signed [DATA_W-1:0] x_velocity_flux;
    logic [1:0]               status;
  } out_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_SAT     = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    OP_MUL, OP_DIV, OP_SQRT, OP_ADD, OP_SUB, OP_HADD, OP_ADDH, OP_SUBH, OP_ADDHB
  } op_e;

  typedef enum logic [3:0] {
    T_T0, T_T1, T_T2, T_GPL, T_CL, T_CR, T_D, T_ZL, T_ZR, T_W0, T_W1, T_P, T_U,
    T_UF, T_PF
  } tmp_e;

  // Codes with bit 5 set live in the scratch memory.
  typedef enum logic [5:0] {
    O_PL = 6'd0, O_UL = 6'd1, O_VL = 6'd2, O_WL = 6'd3, O_P0L = 6'd4,
    O_RHOL = 6'd5, O_U0L = 6'd6, O_V0L = 6'd7, O_W0L = 6'd8,
    O_PR = 6'd9, O_UR = 6'd10, O_VR = 6'd11, O_WR = 6'd12, O_P0R = 6'd13,
    O_RHOR = 6'd14, O_U0R = 6'd15, O_G = 6'd16, O_X0P = 6'd17, O_X1P = 6'd18,
    O_T0 = 6'd32, O_T1 = 6'd33, O_T2 = 6'd34, O_GPL = 6'd35, O_CL = 6'd36,
    O_CR = 6'd37, O_D = 6'd38, O_ZL = 6'd39, O_ZR = 6'd40, O_W0 = 6'd41,
    O_W1 = 6'd42, O_P = 6'd43, O_U = 6'd44, O_UF = 6'd45, O_PF = 6'd46,
    O_X0Z = 6'd48, O_X1Z = 6'd49
  } opnd_e;

  typedef enum logic [1:0] {FL_NONE, FL_LAM0, FL_LAM1, FL_DZERO} flag_e;

  typedef struct packed {
    op_e   op;
    opnd_e a;
    opnd_e b;
    tmp_e  dst;
    flag_e flag;
  } uop_t;

  typedef struct packed {
    logic [IW-1:0] val;
    logic          sat;
  } res_t;

  typedef struct packed {
    logic          start;
    op_e           op;
    logic [IW-1:0] a;
    logic [IW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [IW-1:0] val;
    logic          sat;
  } alu_rsp_t;

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_SQRT, A_FIN, A_DONE} alu_e;

  typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_ISSUE, ST_WAIT, ST_FINISH} ctl_e;

  // Program for one right item. The X operands follow the sign of the waves.
  function automatic uop_t auf_uop(logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      5'd0:    u = '{OP_MUL,   O_G,    O_P0L,  T_GPL, FL_NONE};
      5'd1:    u = '{OP_DIV,   O_GPL,  O_RHOL, T_T0,  FL_NONE};
      5'd2:    u = '{OP_SQRT,  O_T0,   O_T0,   T_CL,  FL_NONE};
      5'd3:    u = '{OP_MUL,   O_G,    O_P0R,  T_T0,  FL_NONE};
      5'd4:    u = '{OP_DIV,   O_T0,   O_RHOR, T_T0,  FL_NONE};
      5'd5:    u = '{OP_SQRT,  O_T0,   O_T0,   T_CR,  FL_NONE};
      5'd6:    u = '{OP_MUL,   O_CL,   O_RHOL, T_D,   FL_DZERO};
      5'd7:    u = '{OP_HADD,  O_U0L,  O_U0R,  T_T0,  FL_NONE};
      5'd8:    u = '{OP_HADD,  O_CL,   O_CR,   T_T1,  FL_NONE};
      5'd9:    u = '{OP_ADD,   O_T0,   O_T1,   T_T2,  FL_LAM0};
      5'd10:   u = '{OP_SUB,   O_T0,   O_T1,   T_T2,  FL_LAM1};
      5'd11:   u = '{OP_MUL,   O_UL,   O_CL,   T_T0,  FL_NONE};
      5'd12:   u = '{OP_MUL,   O_T0,   O_RHOL, T_ZL,  FL_NONE};
      5'd13:   u = '{OP_MUL,   O_UR,   O_CR,   T_T0,  FL_NONE};
      5'd14:   u = '{OP_MUL,   O_T0,   O_RHOR, T_ZR,  FL_NONE};
      5'd15:   u = '{OP_ADDH,  O_X0P,  O_X0Z,  T_W0,  FL_NONE};
      5'd16:   u = '{OP_SUBH,  O_X1P,  O_X1Z,  T_W1,  FL_NONE};
      5'd17:   u = '{OP_ADD,   O_W0,   O_W1,   T_P,   FL_NONE};
      5'd18:   u = '{OP_SUB,   O_W0,   O_W1,   T_T0,  FL_NONE};
      5'd19:   u = '{OP_DIV,   O_T0,   O_D,    T_U,   FL_NONE};
      5'd20:   u = '{OP_MUL,   O_GPL,  O_U,    T_T0,  FL_NONE};
      5'd21:   u = '{OP_MUL,   O_U0L,  O_P,    T_T1,  FL_NONE};
      5'd22:   u = '{OP_ADD,   O_T0,   O_T1,   T_PF,  FL_NONE};
      5'd23:   u = '{OP_DIV,   O_P,    O_RHOL, T_UF,  FL_NONE};
      5'd24:   u = '{OP_MUL,   O_U0L,  O_U,    T_T0,  FL_NONE};
      5'd25:   u = '{OP_ADD,   O_UF,   O_T0,   T_UF,  FL_NONE};
      5'd26:   u = '{OP_ADD,   O_VL,   O_VR,   T_T0,  FL_NONE};
      5'd27:   u = '{OP_MUL,   O_V0L,  O_T0,   T_T0,  FL_NONE};
      5'd28:   u = '{OP_ADDHB, O_UF,   O_T0,   T_UF,  FL_NONE};
      5'd29:   u = '{OP_ADD,   O_WL,   O_WR,   T_T0,  FL_NONE};
      5'd30:   u = '{OP_MUL,   O_W0L,  O_T0,   T_T0,  FL_NONE};
      5'd31:   u = '{OP_ADDHB, O_UF,   O_T0,   T_UF,  FL_NONE};
      default: u = '{OP_ADD,   O_T0,   O_T0,   T_T0,  FL_NONE};
    endcase
    return u;
  endfunction

  // Signed result from a magnitude; ovf flags magnitude bits above 64.
  function automatic res_t from_mag(logic neg, logic ovf, logic [IW-1:0] lo);
    res_t r;
    if (neg) begin
      if (ovf || (lo > S64_MIN)) r = '{S64_MIN, 1'b1};
      else                       r = '{64'd0 - lo, 1'b0};
    end else begin
      if (ovf || lo[IW-1]) r = '{S64_MAX, 1'b1};
      else                 r = '{lo, 1'b0};
    end
    return r;
  endfunction

  function automatic res_t sat_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    res_t r;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) r = '{(s[IW] ? S64_MIN : S64_MAX), 1'b1};
    else                  r = '{s[IW-1:0], 1'b0};
    return r;
  endfunction

  function automatic res_t sat_sub(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    res_t r;
    s = {a[IW-1], a} - {b[IW-1], b};
    if (s[IW] != s[IW-1]) r = '{(s[IW] ? S64_MIN : S64_MAX), 1'b1};
    else                  r = '{s[IW-1:0], 1'b0};
    return r;
  endfunction

  // Halving that rounds toward zero.
  function automatic logic [IW-1:0] half(logic [IW-1:0] a);
    logic [IW-1:0] t;
    t = a + {{(IW-1){1'b0}}, a[IW-1]};
    return {t[IW-1], t[IW-1:1]};
  endfunction

  function automatic logic [IW-1:0] mag(logic [IW-1:0] a);
    return a[IW-1] ? (64'd0 - a) : a;
  endfunction

endpackage

@@ hw/rtl/auf_alu.sv @@
// Shared arithmetic unit: saturating add forms, 64-bit fixed-point multiply
// over four 32x32 partial products, restoring divide and square root.
// Depends on auf_pkg.
module auf_alu import auf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam logic [6:0] MUL_LAST  = 7'd3;
  localparam logic [6:0] DIV_LAST  = 7'd127;
  localparam logic [6:0] SQRT_LAST = 7'd63;

  alu_e state_q, state_d;
  logic [6:0]    cnt_q, cnt_d;
  op_e           op_q, op_d;
  logic          neg_q, neg_d;
  logic [IW-1:0] ma_q, ma_d, mb_q, mb_d;
  logic [127:0]  acc_q, acc_d;
  logic [66:0]   rem_q, rem_d;
  logic [IW-1:0] q_q, q_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] res_q, res_d;
  logic          sat_q, sat_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_MUL:  state_d = A_MUL;
            OP_DIV:  state_d = A_DIV;
            OP_SQRT: state_d = A_SQRT;
            default: state_d = A_DONE;
          endcase
        end
      end
      A_MUL:   if (cnt_q == MUL_LAST)  state_d = A_FIN;
      A_DIV:   if (cnt_q == DIV_LAST)  state_d = A_FIN;
      A_SQRT:  if (cnt_q == SQRT_LAST) state_d = A_FIN;
      A_FIN:   state_d = A_DONE;
      A_DONE:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp_o.done = (state_q == A_DONE);
    rsp_o.val  = res_q;
    rsp_o.sat  = sat_q;
  end

  // Datapath.
  always_comb begin
    res_t          simple;
    res_t          fin;
    logic [31:0]   a_half, b_half;
    logic [63:0]   pp;
    logic [127:0]  pp_sh;
    logic [127:0]  shifted;
    logic [64:0]   rsh, rdif;
    logic [66:0]   rem2, trial;
    logic [67:0]   sdif;
    cnt_d = cnt_q;
    op_d  = op_q;
    neg_d = neg_q;
    ma_d  = ma_q;
    mb_d  = mb_q;
    acc_d = acc_q;
    rem_d = rem_q;
    q_d   = q_q;
    ovf_d = ovf_q;
    res_d = res_q;
    sat_d = sat_q;

    case (req_i.op)
      OP_ADD:   simple = sat_add(req_i.a, req_i.b);
      OP_SUB:   simple = sat_sub(req_i.a, req_i.b);
      OP_HADD:  begin
        simple     = sat_add(req_i.a, req_i.b);
        simple.val = half(simple.val);
      end
      OP_ADDH:  simple = sat_add(half(req_i.a), half(req_i.b));
      OP_SUBH:  simple = sat_sub(half(req_i.a), half(req_i.b));
      OP_ADDHB: simple = sat_add(req_i.a, half(req_i.b));
      default:  simple = '{'0, 1'b0};
    endcase

    a_half = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
    b_half = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp     = a_half * b_half;
    case ({cnt_q[1], cnt_q[0]})
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase

    rsh  = {rem_q[63:0], acc_q[127]};
    rdif = rsh - {1'b0, mb_q};

    rem2  = {rem_q[64:0], acc_q[127:126]};
    trial = {1'b0, q_q, 2'b01};
    sdif  = {1'b0, rem2} - {1'b0, trial};

    shifted = acc_q >> FRAC_BITS;
    case (op_q)
      OP_MUL:  fin = from_mag(neg_q, |shifted[127:64], shifted[63:0]);
      OP_DIV:  fin = from_mag(neg_q, ovf_q, q_q);
      default: fin = from_mag(1'b0, 1'b0, q_q);
    endcase

    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          neg_d = req_i.a[IW-1] ^ req_i.b[IW-1];
          ma_d  = mag(req_i.a);
          mb_d  = mag(req_i.b);
          cnt_d = '0;
          rem_d = '0;
          q_d   = '0;
          ovf_d = 1'b0;
          acc_d = (req_i.op == OP_MUL) ? '0 : ({64'd0, mag(req_i.a)} << FRAC_BITS);
          res_d = simple.val;
          sat_d = simple.sat;
        end
      end
      A_MUL: begin
        acc_d = acc_q + pp_sh;
        cnt_d = cnt_q + 7'd1;
      end
      A_DIV: begin
        acc_d = {acc_q[126:0], 1'b0};
        rem_d = {3'd0, (!rdif[64]) ? rdif[63:0] : rsh[63:0]};
        ovf_d = ovf_q | q_q[63];
        q_d   = {q_q[62:0], !rdif[64]};
        cnt_d = cnt_q + 7'd1;
      end
      A_SQRT: begin
        acc_d = {acc_q[125:0], 2'b00};
        rem_d = (!sdif[67]) ? sdif[66:0] : rem2;
        q_d   = {q_q[62:0], !sdif[67]};
        cnt_d = cnt_q + 7'd1;
      end
      A_FIN: begin
        res_d = fin.val;
        sat_d = fin.sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    q_q   <= q_d;
    ovf_q <= ovf_d;
    res_q <= res_d;
    sat_q <= sat_d;
  end

endmodule

@@ hw/rtl/acoustic_upwind_flux.sv @@
// Upwind interface flux of the linear acoustic perturbation equations.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one side per
// transfer. A left transfer (side 0) is stored as left state and gives no
// result. A right transfer (side 1) is combined with the stored left state
// and gives one result on the output channel (out_valid_o/out_ready_i/
// out_data_o) with the pressure flux, the x-velocity flux and a status.
// A right item is mostly spent in iterative work: a small sequencer runs
// 32 steps through one shared unit, and the four 128-step divisions and
// two 64-step square roots dominate. An invalid base state is found at
// the transfer and goes straight to the finish state.
// The input is not ready while a right item is in work.
// The output register holds a result until it is taken; further left items
// are accepted meanwhile, but a finished right item waits for the slot.
// Reset clears the stored left state to zero and sets gamma to 1.4.
// cfg_we_i sets gamma (unsigned Q3.16); use only while idle, not enforced.
// Depends on auf_pkg, auf_alu and acoustic_upwind_flux_defines.svh.
`include "acoustic_upwind_flux_defines.svh"

module acoustic_upwind_flux import auf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [GAMMA_W-1:0] cfg_data_i
);

  ctl_e state_q, state_d;
  logic [STEP_W-1:0]  step_q;
  logic [GAMMA_W-1:0] gamma_q;
  in_t                held_q, rgt_q;
  logic               err_q, sat_q, lam0n_q, lam1n_q;
  logic [IW-1:0]      pf_q, uf_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [IW-1:0] tmp_mem [16];
  logic [IW-1:0] rd_a_q, rd_b_q;

  uop_t     uop;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     in_xfer, wb, out_load, invalid, dzero;

  function automatic logic [IW-1:0] sx(logic [DATA_W-1:0] v);
    return {{(IW-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic nonpos(logic [DATA_W-1:0] v);
    return v[DATA_W-1] || (v == '0);
  endfunction

  function automatic logic [IW-1:0] named_val(opnd_e c, in_t l, in_t r,
                                              logic [GAMMA_W-1:0] g,
                                              logic n0, logic n1);
    logic [IW-1:0] v;
    case (c)
      O_PL:    v = sx(l.pressure);
      O_UL:    v = sx(l.x_velocity);
      O_VL:    v = sx(l.y_velocity);
      O_WL:    v = sx(l.z_velocity);
      O_P0L:   v = sx(l.base_pressure);
      O_RHOL:  v = sx(l.base_density);
      O_U0L:   v = sx(l.base_x_velocity);
      O_V0L:   v = sx(l.base_y_velocity);
      O_W0L:   v = sx(l.base_z_velocity);
      O_PR:    v = sx(r.pressure);
      O_UR:    v = sx(r.x_velocity);
      O_VR:    v = sx(r.y_velocity);
      O_WR:    v = sx(r.z_velocity);
      O_P0R:   v = sx(r.base_pressure);
      O_RHOR:  v = sx(r.base_density);
      O_U0R:   v = sx(r.base_x_velocity);
      O_G:     v = {{(IW-GAMMA_W){1'b0}}, g};
      O_X0P:   v = n0 ? sx(r.pressure) : sx(l.pressure);
      O_X1P:   v = n1 ? sx(r.pressure) : sx(l.pressure);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Scratch address; the wave-selected products pick left or right.
  function automatic tmp_e tmp_addr(opnd_e c, logic n0, logic n1);
    tmp_e t;
    case (c)
      O_X0Z:   t = n0 ? T_ZR : T_ZL;
      O_X1Z:   t = n1 ? T_ZR : T_ZL;
      default: t = tmp_e'(c[3:0]);
    endcase
    return t;
  endfunction

  function automatic res_t clamp_out(logic [IW-1:0] v);
    res_t r;
    if ((&v[IW-1:DATA_W-1]) || !(|v[IW-1:DATA_W-1])) r = '{v, 1'b0};
    else if (v[IW-1]) r = '{sx({1'b1, {(DATA_W-1){1'b0}}}), 1'b1};
    else              r = '{{{(IW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}, 1'b1};
    return r;
  endfunction

  assign uop     = auf_uop(step_q);
  assign in_xfer = in_valid_i && in_ready_o;
  assign invalid = nonpos(held_q.base_density) || nonpos(in_data_i.base_density) ||
                   held_q.base_pressure[DATA_W-1] || in_data_i.base_pressure[DATA_W-1];
  assign dzero   = (uop.flag == FL_DZERO) && (alu_rsp.val == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_xfer && in_data_i.side) state_d = invalid ? ST_FINISH : ST_FETCH;
      ST_FETCH:  state_d = ST_ISSUE;
      ST_ISSUE:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (alu_rsp.done) begin
          if (dzero || (step_q == LAST_STEP)) state_d = ST_FINISH;
          else                                state_d = ST_FETCH;
        end
      end
      ST_FINISH: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    wb            = (state_q == ST_WAIT) && alu_rsp.done;
    out_load      = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
    alu_req.start = (state_q == ST_ISSUE);
    alu_req.op    = uop.op;
    alu_req.a     = uop.a[5] ? rd_a_q :
                    named_val(uop.a, held_q, rgt_q, gamma_q, lam0n_q, lam1n_q);
    alu_req.b     = uop.b[5] ? rd_b_q :
                    named_val(uop.b, held_q, rgt_q, gamma_q, lam0n_q, lam1n_q);
  end

  auf_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (wb) begin
      tmp_mem[uop.dst] <= alu_rsp.val;
    end
    rd_a_q <= tmp_mem[tmp_addr(uop.a, lam0n_q, lam1n_q)];
    rd_b_q <= tmp_mem[tmp_addr(uop.b, lam0n_q, lam1n_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      gamma_q     <= GAMMA_RESET;
      held_q      <= '0;
      err_q       <= 1'b0;
      sat_q       <= 1'b0;
      lam0n_q     <= 1'b0;
      lam1n_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        gamma_q <= cfg_data_i;
      end
      if (in_xfer && !in_data_i.side) begin
        held_q <= in_data_i;
      end
      if (in_xfer && in_data_i.side) begin
        step_q <= '0;
        err_q  <= invalid;
        sat_q  <= 1'b0;
      end
      if (wb) begin
        step_q <= step_q + 5'd1;
        sat_q  <= sat_q | alu_rsp.sat;
        if (dzero) err_q <= 1'b1;
        if (uop.flag == FL_LAM0) lam0n_q <= alu_rsp.val[IW-1];
        if (uop.flag == FL_LAM1) lam1n_q <= alu_rsp.val[IW-1];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_t pfc, ufc;
    pfc = clamp_out(pf_q);
    ufc = clamp_out(uf_q);
    if (in_xfer && in_data_i.side) begin
      rgt_q <= in_data_i;
    end
    if (wb && (uop.dst == T_PF)) pf_q <= alu_rsp.val;
    if (wb && (uop.dst == T_UF)) uf_q <= alu_rsp.val;
    if (out_load) begin
      if (err_q) begin
        out_q.pressure_flux   <= '0;
        out_q.x_velocity_flux <= '0;
        out_q.status          <= STAT_INVALID;
      end else begin
        out_q.pressure_flux   <= pfc.val[DATA_W-1:0];
        out_q.x_velocity_flux <= ufc.val[DATA_W-1:0];
        out_q.status          <= (sat_q || pfc.sat || ufc.sat) ? STAT_SAT : STAT_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `AUF_ASSERT_IMP(a_done_in_wait, alu_rsp.done, state_q == ST_WAIT, "unit result outside wait")
  `AUF_ASSERT_NXT(a_right_starts, in_xfer && in_data_i.side, state_q != ST_IDLE, "right item lost")
  `AUF_ASSERT_IMP(a_invalid_zero, out_valid_o && (out_data_o.status == STAT_INVALID),
                  (out_data_o.pressure_flux == '0) && (out_data_o.x_velocity_flux == '0),
                  "error result carries nonzero flux")

endmodule
